[rtl/nint_pkg.sv]
package nint_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS = 24;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 40;
    localparam int H_W       = IN_W + 1;
    localparam int X_W       = IN_W + 2;
    localparam int UX_W      = 32;
    localparam int SQ_W      = 2 * UX_W - FRAC_BITS;
    localparam int DEN_W     = SQ_W + 1;
    localparam int SMP_W     = 2 * FRAC_BITS + 3;
    localparam int DIV_RADIX = 2;
    localparam int DIV_W     = ((SMP_W + DIV_RADIX - 1) / DIV_RADIX) * DIV_RADIX;
    localparam int DIV_ITER  = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);
    localparam int ACC_W     = 63;
    localparam int M_W       = 32;
    localparam int PLO_W     = 2 * M_W;
    localparam int PHI_W     = (ACC_W - M_W) + M_W;
    localparam int PROD_W    = ACC_W + M_W;
    localparam int SH_W      = PROD_W - FRAC_BITS;

    // Divide by three: floor(x * RECIP3 / 2^RECIP3_SH) is exact for 32-bit x
    localparam logic [M_W-1:0] RECIP3    = 32'hAAAA_AAAB;
    localparam int             RECIP3_SH = 33;

    // Method and integrand codes
    localparam logic OP_TRAP     = 1'b0;
    localparam logic OP_SIMPSON  = 1'b1;
    localparam logic FN_INV_SQ   = 1'b0;
    localparam logic FN_ARCTAN   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_N   = 2'd1,
        STATUS_DIV_ZERO = 2'd2,
        STATUS_SAT      = 2'd3
    } nint_status_t;

    typedef struct packed {
        logic               opcode;
        logic               integrand;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic [14:0]        intervals;
    } nint_in_t;

    typedef struct packed {
        logic signed [39:0] integral;
        nint_status_t       status;
    } nint_out_t;

    typedef enum logic [1:0] {
        DIV_SRC_H,
        DIV_SRC_S
    } nint_div_src_t;

    typedef enum logic [1:0] {
        XSEL_A,
        XSEL_B,
        XSEL_K
    } nint_xsel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_FA,
        ACC_FB,
        ACC_ADD
    } nint_acc_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDIV,
        S_HWAIT,
        S_MDIV,
        S_SQ,
        S_SDIV,
        S_SWAIT,
        S_MUL_LO,
        S_MUL_HI,
        S_FIN
    } nint_state_t;

    typedef struct packed {
        logic          load;
        logic          div_start;
        nint_div_src_t div_src;
        logic          h_load;
        logic          m_load;
        nint_xsel_t    x_sel;
        logic          sq_load;
        nint_acc_op_t  acc_op;
        logic          k_init;
        logic          k_step;
        logic          mul_lo;
        logic          mul_hi;
        logic          out_load;
    } nint_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic simpson;
        logic div_done;
        logic k_none;
        logic k_last;
        logic out_busy;
    } nint_stat_t;

endpackage

[rtl/nint_div.sv]
module nint_div
    import nint_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     work_reg, work_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W-1:0]     rem_step;
    logic [DIV_W-1:0]     work_step;
    logic [DEN_W:0]       trial;

    // Restoring division, DIV_RADIX quotient bits per cycle
    always_comb
    begin
        rem_step  = rem_reg;
        work_step = work_reg;
        trial     = '0;
        for (int i = 0; i < DIV_RADIX; i++)
        begin
            trial     = {rem_step, work_step[DIV_W-1]};
            work_step = work_step << 1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_step     = DEN_W'(trial - {1'b0, den_reg});
                work_step[0] = 1'b1;
            end
            else
            begin
                rem_step = trial[DEN_W-1:0];
            end
        end
    end

    // Sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            work_next = work_step;
            rem_next  = rem_step;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

[rtl/nint_datapath.sv]
module nint_datapath
    import nint_pkg::*;
#(
    parameter int MAX_INTERVALS = 16384
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  nint_cmd_t  cmd,
    output nint_stat_t stat,
    input  nint_in_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output nint_out_t  out_data
);

    localparam int NW = $clog2(MAX_INTERVALS + 1);
    localparam int KW = $clog2(2 * MAX_INTERVALS + 1);

    nint_in_t              in_reg;
    logic [NW-1:0]         n_reg;
    logic signed [H_W-1:0] h_reg;
    logic                  hneg_reg;
    logic [M_W-1:0]        m_reg;
    logic signed [X_W-1:0] x_reg;
    logic [KW-1:0]         k_reg;
    logic [SQ_W-1:0]       x2_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic                  sat_reg;
    logic                  dz_reg;
    logic [PLO_W-1:0]      plo_reg;
    logic [PHI_W-1:0]      phi_reg;
    nint_out_t             out_reg;
    logic                  out_valid_reg;

    logic [NW-1:0]         n_eff;
    logic [KW-1:0]         n_div;
    logic [KW-1:0]         k_max;
    logic signed [H_W-1:0] diff;
    logic                  diff_neg;
    logic [M_W-1:0]        diff_mag;
    logic [M_W-1:0]        hq;
    logic signed [X_W-1:0] xs;
    logic [X_W-1:0]        ax;
    logic [UX_W-1:0]       ux;
    logic [DEN_W-1:0]      den;
    logic [DIV_W-1:0]      div_dividend;
    logic [DEN_W-1:0]      div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [DIV_W-1:0]      div_q;
    logic                  smp_dz;
    logic [SMP_W-1:0]      smp;
    logic [ACC_W-1:0]      addend;
    logic [ACC_W:0]        acc_sum;
    logic [ACC_W:0]        end_sum;
    logic [PROD_W-1:0]     prod;
    logic [SH_W-1:0]       sh;
    logic [SH_W-1:0]       lim;
    logic                  mneg;
    logic                  over;
    logic [OUT_W-1:0]      mag;
    nint_out_t             result;

    // Interval count clamp and sample count
    always_comb
    begin
        if (32'(in_data.intervals) > MAX_INTERVALS)
            n_eff = NW'(MAX_INTERVALS);
        else
            n_eff = NW'(in_data.intervals);
        if (in_reg.opcode == OP_SIMPSON)
            n_div = KW'(n_reg) << 1;
        else
            n_div = KW'(n_reg);
        k_max = n_div - 1'b1;
    end

    // Interval width
    always_comb
    begin
        diff     = H_W'(in_reg.upper_bound) - H_W'(in_reg.lower_bound);
        diff_neg = diff < 0;
        diff_mag = diff_neg ? M_W'(-diff) : M_W'(diff);
        hq       = div_q[M_W-1:0];
    end

    // Sample point and its square
    always_comb
    begin
        case (cmd.x_sel)
            XSEL_A:  xs = X_W'(in_reg.lower_bound);
            XSEL_B:  xs = X_W'(in_reg.upper_bound);
            default: xs = x_reg;
        endcase
        ax = (xs < 0) ? X_W'(-xs) : X_W'(xs);
        ux = (ax > X_W'({UX_W{1'b1}})) ? {UX_W{1'b1}} : ax[UX_W-1:0];
    end

    // Divider operand selection
    always_comb
    begin
        if (in_reg.integrand == FN_ARCTAN)
            den = DEN_W'(x2_reg) + (DEN_W'(1) << FRAC_BITS);
        else
            den = DEN_W'(x2_reg);
        case (cmd.div_src)
            DIV_SRC_H:
            begin
                div_dividend = DIV_W'(diff_mag);
                div_divisor  = DEN_W'(n_div);
            end
            default:
            begin
                if (in_reg.integrand == FN_ARCTAN)
                    div_dividend = DIV_W'(4) << (2 * FRAC_BITS);
                else
                    div_dividend = DIV_W'(2) << (2 * FRAC_BITS);
                div_divisor = den;
            end
        endcase
    end

    nint_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sample weighting and saturating accumulate
    always_comb
    begin
        smp_dz = (in_reg.integrand == FN_INV_SQ) && (x2_reg == '0);
        smp    = smp_dz ? '0 : div_q[SMP_W-1:0];
        if (in_reg.opcode == OP_SIMPSON)
            addend = k_reg[0] ? (ACC_W'(smp) << 2) : (ACC_W'(smp) << 1);
        else
            addend = ACC_W'(smp);
        acc_sum = {1'b0, acc_reg} + {1'b0, addend};
        end_sum = {1'b0, acc_reg} + (ACC_W + 1)'(smp);
    end

    // Final scaling, clamp and status
    always_comb
    begin
        prod   = PROD_W'(plo_reg) + (PROD_W'(phi_reg) << M_W);
        sh     = prod[PROD_W-1:FRAC_BITS];
        mneg   = hneg_reg && (m_reg != '0);
        lim    = mneg ? (SH_W'(1) << (OUT_W - 1)) : ((SH_W'(1) << (OUT_W - 1)) - 1'b1);
        over   = sh > lim;
        mag    = over ? lim[OUT_W-1:0] : sh[OUT_W-1:0];
        result.integral = mneg ? -$signed(mag) : $signed(mag);
        result.status   = STATUS_OK;
        if (in_reg.intervals == '0)
        begin
            result.integral = '0;
            result.status   = STATUS_ZERO_N;
        end
        else if (dz_reg)
        begin
            result.integral = '0;
            result.status   = STATUS_DIV_ZERO;
        end
        else if (sat_reg || over)
        begin
            result.status = STATUS_SAT;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
            n_reg  <= n_eff;
        end
        if (cmd.h_load)
        begin
            h_reg    <= diff_neg ? -$signed({1'b0, hq}) : $signed({1'b0, hq});
            hneg_reg <= diff_neg;
            m_reg    <= hq;
        end
        if (cmd.m_load)
            m_reg <= M_W'((PLO_W'(m_reg) * PLO_W'(RECIP3)) >> RECIP3_SH);
        if (cmd.sq_load)
            x2_reg <= SQ_W'((PLO_W'(ux) * PLO_W'(ux)) >> FRAC_BITS);
        if (cmd.k_init)
        begin
            k_reg <= KW'(1);
            x_reg <= X_W'(in_reg.lower_bound) + X_W'(h_reg);
        end
        else if (cmd.k_step)
        begin
            k_reg <= k_reg + 1'b1;
            x_reg <= x_reg + X_W'(h_reg);
        end
        case (cmd.acc_op)
            ACC_FA:  acc_reg <= ACC_W'(smp);
            ACC_FB:
            begin
                if (in_reg.opcode == OP_SIMPSON)
                    acc_reg <= end_sum[ACC_W-1:0];
                else
                    acc_reg <= end_sum[ACC_W:1];
            end
            ACC_ADD: acc_reg <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
            default: acc_reg <= acc_reg;
        endcase
        if (cmd.mul_lo)
            plo_reg <= PLO_W'(acc_reg[M_W-1:0]) * PLO_W'(m_reg);
        if (cmd.mul_hi)
            phi_reg <= PHI_W'(acc_reg[ACC_W-1:M_W]) * PHI_W'(m_reg);
        if (cmd.out_load)
            out_reg <= result;
    end

    // Flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg       <= 1'b0;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                sat_reg <= 1'b0;
                dz_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.acc_op == ACC_ADD && acc_sum[ACC_W])
                    sat_reg <= 1'b1;
                if (cmd.acc_op != ACC_NONE && smp_dz)
                    dz_reg <= 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.in_zero  = in_data.intervals == '0;
        stat.simpson  = in_reg.opcode == OP_SIMPSON;
        stat.div_done = div_done;
        stat.k_none   = k_max == '0;
        stat.k_last   = k_reg == k_max;
        stat.out_busy = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> !div_done)
        else $error("divider done held longer than one cycle");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.k_step |-> (k_reg <= k_max))
        else $error("sample index ran past the last sample");
`endif

endmodule

[rtl/nint_ctrl.sv]
module nint_ctrl
    import nint_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  nint_stat_t stat,
    output nint_cmd_t  cmd
);

    nint_state_t state_reg, state_next;
    nint_xsel_t  smp_reg, smp_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        smp_next   = smp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = stat.in_zero ? S_FIN : S_HDIV;
            end
            S_HDIV:  state_next = S_HWAIT;
            S_HWAIT:
            begin
                if (stat.div_done)
                begin
                    smp_next   = XSEL_A;
                    state_next = stat.simpson ? S_MDIV : S_SQ;
                end
            end
            S_MDIV:  state_next = S_SQ;
            S_SQ:    state_next = S_SDIV;
            S_SDIV:  state_next = S_SWAIT;
            S_SWAIT:
            begin
                if (stat.div_done)
                begin
                    case (smp_reg)
                        XSEL_A:
                        begin
                            smp_next   = XSEL_B;
                            state_next = S_SQ;
                        end
                        XSEL_B:
                        begin
                            smp_next   = XSEL_K;
                            state_next = stat.k_none ? S_MUL_LO : S_SQ;
                        end
                        default: state_next = stat.k_last ? S_MUL_LO : S_SQ;
                    endcase
                end
            end
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_FIN;
            S_FIN:
            begin
                if (!stat.out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.div_src  = DIV_SRC_S;
        cmd.x_sel    = smp_reg;
        cmd.acc_op   = ACC_NONE;
        in_stall     = state_reg != S_IDLE;
        case (state_reg)
            S_IDLE:  cmd.load = in_valid;
            S_HDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_SRC_H;
            end
            S_HWAIT: cmd.h_load = stat.div_done;
            S_MDIV:  cmd.m_load = 1'b1;
            S_SQ:    cmd.sq_load = 1'b1;
            S_SDIV:  cmd.div_start = 1'b1;
            S_SWAIT:
            begin
                if (stat.div_done)
                begin
                    case (smp_reg)
                        XSEL_A:  cmd.acc_op = ACC_FA;
                        XSEL_B:
                        begin
                            cmd.acc_op = ACC_FB;
                            cmd.k_init = 1'b1;
                        end
                        default:
                        begin
                            cmd.acc_op = ACC_ADD;
                            cmd.k_step = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL_LO: cmd.mul_lo = 1'b1;
            S_MUL_HI: cmd.mul_hi = 1'b1;
            S_FIN:    cmd.out_load = !stat.out_busy;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            smp_reg   <= XSEL_A;
        end
        else
        begin
            state_reg <= state_next;
            smp_reg   <= smp_next;
        end
    end

endmodule

[rtl/numeric_integrator.sv]
// Definite integral of 2/x^2 or 4/(1+x^2) by the trapezoidal or Simpson rule.
// Input channel in_valid/in_stall/in_data carries one job per transfer:
// method, integrand, bounds (Q8.24) and interval count. Output channel
// out_valid/out_stall/out_data returns one result per job: a saturated
// Q16.24 integral and a status code.
// One job is worked at a time. Every integrand sample is one pass through
// the shared radix-4 divider (26 steps). A job uses the divider once for
// h, then once for each end sample and each of its S interior samples
// (n-1 trapezoid, 2n-1 Simpson); Simpson adds h/3 (reciprocal multiply).
// A zero interval count skips the divider and goes straight to its result.
// A finished result sits in the output register; the next job is taken
// while it waits. If the receiver stalls, the block holds its next result
// at the end of its job and takes no new job until the register frees.
// Reset (rst_n low, asynchronous) empties the output register and returns
// the controller to idle.
module numeric_integrator
    import nint_pkg::*;
#(
    parameter int MAX_INTERVALS = 16384
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  nint_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output nint_out_t out_data
);

    nint_cmd_t  cmd;
    nint_stat_t stat;

    nint_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    nint_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[tb/tb_top.sv]
module tb_top;
    import nint_pkg::*;

    localparam int N_RANDOM     = 100;
    localparam int MAX_CYCLES   = 4_000_000;
    localparam int TAIL_CYCLES  = 200;
    localparam int CALM_TAIL    = 20;
    localparam longint ONE      = 64'sd1 << FRAC_BITS;
    localparam logic [63:0] SMP_MAX  = (64'd1 << 60) - 64'd1;
    localparam logic [63:0] SUM_MAX  = (64'd1 << 63) - 64'd1;
    localparam logic [63:0] POS_LIM  = (64'd1 << 39) - 64'd1;
    localparam logic [63:0] NEG_LIM  = 64'd1 << 39;
    localparam int CAP_N        = 16384;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    nint_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    nint_out_t out_data;

    nint_in_t  job_q[$];
    nint_out_t integral_q[$];
    int        errors;
    int        sent;
    int        total_jobs;
    int        hold_at;
    int        cycles;
    logic      in_fire;
    int        in_idle;
    int        out_idle;

    numeric_integrator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // floor(c * 2^48 / den), clamped to the sample ceiling
    function automatic logic [63:0] scaled_recip(logic [63:0] c, logic [63:0] den,
                                                 inout bit sat);
        logic [63:0] q;
        logic [63:0] r;
        q = c / den;
        r = c % den;
        for (int i = 0; i < 2 * FRAC_BITS; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
            if (q > SMP_MAX)
            begin
                sat = 1'b1;
                return SMP_MAX;
            end
        end
        return q;
    endfunction

    // integrand value at x
    function automatic logic [63:0] f_at(logic fsel, longint x, inout bit dz, inout bit sat);
        logic [63:0] ux;
        logic [63:0] x2;
        ux = (x < 0) ? 64'(-x) : 64'(x);
        if (ux > 64'hFFFF_FFFF)
            ux = 64'hFFFF_FFFF;
        x2 = (ux * ux) >> FRAC_BITS;
        if (fsel == FN_INV_SQ)
        begin
            if (x2 == 0)
            begin
                dz = 1'b1;
                return 64'd0;
            end
            return scaled_recip(64'd2, x2, sat);
        end
        return scaled_recip(64'd4, 64'(ONE) + x2, sat);
    endfunction

    function automatic logic [63:0] sum_sat(logic [63:0] acc, logic [63:0] v, inout bit sat);
        if (acc > SUM_MAX || v > SUM_MAX - acc)
        begin
            sat = 1'b1;
            return SUM_MAX;
        end
        return acc + v;
    endfunction

    // expected result of one job
    function automatic nint_out_t integrate(nint_in_t job);
        nint_out_t   res;
        longint      a;
        longint      b;
        longint      n;
        longint      h;
        longint      m;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] um;
        logic [63:0] lim;
        logic [63:0] mag;
        logic [127:0] p;
        bit          dz;
        bit          sat;
        a = job.lower_bound;
        b = job.upper_bound;
        n = longint'(job.intervals);
        dz = 1'b0;
        sat = 1'b0;
        res.integral = '0;
        if (n == 0)
        begin
            res.status = STATUS_ZERO_N;
            return res;
        end
        if (n > CAP_N)
            n = CAP_N;
        acc = f_at(job.integrand, a, dz, sat);
        s = f_at(job.integrand, b, dz, sat);
        if (job.opcode == OP_TRAP)
        begin
            h = (b - a) / n;
            acc = (acc + s) >> 1;
            for (longint k = 1; k < n; k++)
                acc = sum_sat(acc, f_at(job.integrand, a + k * h, dz, sat), sat);
            m = h;
        end
        else
        begin
            h = (b - a) / (2 * n);
            acc = acc + s;
            for (longint k = 1; k < 2 * n; k++)
            begin
                s = f_at(job.integrand, a + k * h, dz, sat);
                acc = sum_sat(acc, k[0] ? (s << 2) : (s << 1), sat);
            end
            m = h / 3;
        end
        if (dz)
        begin
            res.status = STATUS_DIV_ZERO;
            return res;
        end
        lim = (m < 0) ? NEG_LIM : POS_LIM;
        um = (m < 0) ? 64'(-m) : 64'(m);
        p = 128'(acc) * 128'(um);
        mag = p[87:24];
        if (p[127:88] != 0 || mag > lim)
        begin
            sat = 1'b1;
            mag = lim;
        end
        res.integral = (m < 0) ? -mag[39:0] : mag[39:0];
        res.status = sat ? STATUS_SAT : STATUS_OK;
        return res;
    endfunction

    task automatic add_job(logic op, logic fn, logic [31:0] a, logic [31:0] b,
                           logic [14:0] n);
        nint_in_t j;
        j.opcode = op;
        j.integrand = fn;
        j.lower_bound = a;
        j.upper_bound = b;
        j.intervals = n;
        job_q.push_back(j);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input transfers: predict on acceptance; timeout
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                integral_q.push_back(integrate(in_data));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("numeric_integrator: mismatch");
            $finish;
        end
    end

    // result check
    always @(posedge clk)
    begin
        nint_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (integral_q.size() == 0)
            begin
                $display("%0t: unexpected result integral=%h status=%0d", $realtime,
                         out_data.integral, out_data.status);
                errors++;
            end
            else
            begin
                want = integral_q.pop_front();
                if (out_data.integral !== want.integral)
                begin
                    $display("%0t: integral expected %h actual %h", $realtime,
                             want.integral, out_data.integral);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, out_data.status);
                    errors++;
                end
            end
        end
    end

    // driver: bursts of idle, one drain pause, calm tail
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_fire))
        begin
            if (in_valid && in_fire)
                sent++;
            if (in_idle > 0)
            begin
                in_idle--;
                in_valid <= 1'b0;
            end
            else if (job_q.size() == 0 || (sent == hold_at && integral_q.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else if (sent < total_jobs - CALM_TAIL && $urandom_range(0, 5) == 0)
            begin
                in_idle = $urandom_range(1, 17) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                in_data <= job_q.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_idle > 0)
            begin
                out_idle--;
                out_stall <= 1'b1;
            end
            else if (sent < total_jobs - CALM_TAIL && $urandom_range(0, 5) == 0)
            begin
                out_idle = $urandom_range(1, 17) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic [14:0] n;
        int          mode;
        errors = 0;
        sent = 0;
        cycles = 0;
        in_idle = 0;
        out_idle = 0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        rst_n = 1'b0;

        // directed: zero count, single intervals, end bounds, pole, clamp, saturation
        add_job(OP_TRAP, FN_ARCTAN, 32'h0, 32'h0100_0000, 15'd0);
        add_job(OP_SIMPSON, FN_INV_SQ, 32'h0, 32'h0, 15'd0);
        add_job(OP_TRAP, FN_ARCTAN, 32'h0, 32'h0100_0000, 15'd1);
        add_job(OP_SIMPSON, FN_ARCTAN, 32'h0, 32'h0100_0000, 15'd1);
        add_job(OP_TRAP, FN_ARCTAN, 32'h0, 32'h0100_0000, 15'd8);
        add_job(OP_SIMPSON, FN_ARCTAN, 32'h0, 32'h0100_0000, 15'd8);
        add_job(OP_TRAP, FN_INV_SQ, 32'h0100_0000, 32'h0200_0000, 15'd4);
        add_job(OP_SIMPSON, FN_INV_SQ, 32'h0100_0000, 32'h0200_0000, 15'd4);
        add_job(OP_TRAP, FN_INV_SQ, 32'h0, 32'h0100_0000, 15'd2);
        add_job(OP_SIMPSON, FN_INV_SQ, 32'hFF00_0000, 32'h0100_0000, 15'd1);
        add_job(OP_TRAP, FN_INV_SQ, 32'h0000_0800, 32'h0100_0000, 15'd1);
        add_job(OP_TRAP, FN_INV_SQ, 32'h0000_1000, 32'h7FFF_FFFF, 15'd1);
        add_job(OP_SIMPSON, FN_INV_SQ, 32'h0000_1000, 32'h7FFF_FFFF, 15'd3);
        add_job(OP_TRAP, FN_INV_SQ, 32'h7FFF_FFFF, 32'h0000_1000, 15'd1);
        add_job(OP_TRAP, FN_ARCTAN, 32'h8000_0000, 32'h7FFF_FFFF, 15'd3);
        add_job(OP_SIMPSON, FN_ARCTAN, 32'h7FFF_FFFF, 32'h8000_0000, 15'd2);
        add_job(OP_TRAP, FN_ARCTAN, 32'h8000_0000, 32'h8000_0000, 15'd1);
        add_job(OP_SIMPSON, FN_ARCTAN, 32'h0100_0000, 32'h0, 15'd5);
        add_job(OP_TRAP, FN_ARCTAN, 32'h0, 32'h0100_0000, 15'd32767);
        add_job(OP_SIMPSON, FN_ARCTAN, 32'h0, 32'h0400_0000, 15'd40);

        // random jobs, mostly short counts
        for (int i = 0; i < N_RANDOM; i++)
        begin
            mode = $urandom_range(0, 3);
            a = $urandom;
            b = $urandom;
            if (mode == 1)
            begin
                a = $urandom_range(32'h0000_1000, 32'h1000_0000);
                b = $urandom_range(32'h0000_1000, 32'h1000_0000);
            end
            else if (mode == 2)
            begin
                a = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                b = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            end
            if ($urandom_range(0, 9) == 0)
                n = 15'($urandom_range(0, 300));
            else
                n = 15'($urandom_range(0, 8));
            add_job(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), a, b, n);
        end
        total_jobs = job_q.size();
        hold_at = total_jobs / 2;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (sent == total_jobs);
        wait (integral_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("numeric_integrator: match");
        else
            $display("numeric_integrator: mismatch");
        $finish;
    end

endmodule

[filelist.f]
rtl/nint_pkg.sv
rtl/nint_div.sv
rtl/nint_datapath.sv
rtl/nint_ctrl.sv
rtl/numeric_integrator.sv
tb/tb_top.sv
